// ----- rtl/ovo_linear_svm_three_class_unit_defines.svh -----
// Assertion macros for the one-vs-one SVM unit checker.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef OVO_LINEAR_SVM_THREE_CLASS_UNIT_DEFINES_SVH
`define OVO_LINEAR_SVM_THREE_CLASS_UNIT_DEFINES_SVH

// Same-cycle implication
`define OVSVM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ovsvm check failed");

// Next-cycle implication
`define OVSVM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ovsvm check failed");

`endif

// ----- rtl/ovsvm_pkg.sv -----
package ovsvm_pkg;

	localparam int FEATURE_COUNT = 7;
	localparam int FEATURE_WIDTH = 16;
	localparam int WEIGHT_W      = 16;
	localparam int BIAS_W        = 16;
	localparam int FRAC_BITS     = 12;
	localparam int PAIR_COUNT    = 3;
	localparam int TRAINED_COUNT = 7;

	localparam int PROD_W   = FEATURE_WIDTH + WEIGHT_W;
	localparam int LO_COUNT = (FEATURE_COUNT + 1) / 2;
	localparam int HI_COUNT = FEATURE_COUNT - LO_COUNT;
	// Products, aligned bias and headroom for the sum of all of them
	localparam int ACC_W    = ((PROD_W > BIAS_W + FRAC_BITS) ? PROD_W : BIAS_W + FRAC_BITS)
		+ $clog2(FEATURE_COUNT + 2) + 1;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_BIAS_ZERO_VS_ONE = 2'd0;
	localparam logic [1:0] REG_BIAS_ZERO_VS_TWO = 2'd1;
	localparam logic [1:0] REG_BIAS_ONE_VS_TWO  = 2'd2;

	// Class codes
	localparam logic [1:0] CLASS_ZERO = 2'd0;
	localparam logic [1:0] CLASS_ONE  = 2'd1;
	localparam logic [1:0] CLASS_TWO  = 2'd2;

	localparam logic signed [BIAS_W-1:0] BIAS_ZERO_VS_ONE_RST = -16'sd11499;
	localparam logic signed [BIAS_W-1:0] BIAS_ZERO_VS_TWO_RST = -16'sd5732;
	localparam logic signed [BIAS_W-1:0] BIAS_ONE_VS_TWO_RST  = 16'sd250;

	typedef logic signed [FEATURE_WIDTH-1:0] feat_t;
	typedef logic signed [WEIGHT_W-1:0]      weight_t;
	typedef logic signed [BIAS_W-1:0]        bias_t;
	typedef logic signed [PROD_W-1:0]        prod_t;
	typedef logic signed [ACC_W-1:0]         acc_t;

	typedef feat_t feat_vec_t [FEATURE_COUNT];
	typedef prod_t prod_row_t [FEATURE_COUNT];
	typedef prod_row_t prod_mat_t [PAIR_COUNT];
	typedef bias_t bias_vec_t [PAIR_COUNT];
	typedef acc_t acc_vec_t [PAIR_COUNT];

	typedef struct packed {
		logic signed [15:0] feature_0;
		logic signed [15:0] feature_1;
		logic signed [15:0] feature_2;
		logic signed [15:0] feature_3;
		logic signed [15:0] feature_4;
		logic signed [15:0] feature_5;
		logic signed [15:0] feature_6;
	} feat_word_t;

	typedef struct packed {
		logic [1:0] predicted_class;
		logic [2:0] pair_decisions;
	} class_word_t;

	// Trained hyperplanes, one row per pair (0v1, 0v2, 1v2)
	localparam weight_t WEIGHT_ROM [PAIR_COUNT][TRAINED_COUNT] = '{
		'{-16'sd10159, 16'sd459,  -16'sd4528, -16'sd4262,  -16'sd815,  -16'sd5604, 16'sd3373},
		'{-16'sd7289,  16'sd258,  -16'sd2393, -16'sd5217,  -16'sd2174, 16'sd1279,  -16'sd929},
		'{16'sd8326,   16'sd1661, 16'sd9122,  -16'sd19829, -16'sd2936, 16'sd6310,  -16'sd1425}
	};

	// Features past the trained set carry zero weight
	function automatic weight_t get_weight(input int pair, input int col);
		weight_t w;
		w = '0;
		if (col < TRAINED_COUNT) begin
			w = WEIGHT_ROM[pair][col];
		end
		return w;
	endfunction

endpackage

// ----- rtl/ovsvm_mul.sv -----
module ovsvm_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_vld,
	output logic              up_hold,
	input  ovsvm_pkg::feat_vec_t feat,
	output logic              vld_s1,
	input  logic              dn_hold,
	output ovsvm_pkg::prod_mat_t prod_s1
);
	import ovsvm_pkg::*;

	logic en;

	// Advance when empty or when the next stage takes our word
	assign en      = !vld_s1 || !dn_hold;
	assign up_hold = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up_vld;
		end
	end

	// One constant multiplier per weight
	always_ff @(posedge clk) begin
		if (en && up_vld) begin
			for (int p = 0; p < PAIR_COUNT; p++) begin
				for (int j = 0; j < FEATURE_COUNT; j++) begin
					prod_s1[p][j] <= PROD_W'(feat[j]) * PROD_W'(get_weight(p, j));
				end
			end
		end
	end

endmodule

// ----- rtl/ovsvm_acc.sv -----
module ovsvm_acc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_vld,
	output logic                 up_hold,
	input  ovsvm_pkg::prod_mat_t prod,
	input  ovsvm_pkg::bias_vec_t bias,
	output logic                 vld_s3,
	input  logic                 dn_hold,
	output logic [2:0]           dec_s3
);
	import ovsvm_pkg::*;

	logic     vld_s2;
	logic     en2;
	logic     en3;
	acc_vec_t lo_sum;
	acc_vec_t hi_sum;
	acc_vec_t lo_s2;
	acc_vec_t hi_s2;
	acc_vec_t total;

	assign en3     = !vld_s3 || !dn_hold;
	assign en2     = !vld_s2 || en3;
	assign up_hold = !en2;

	// Split each row in two halves; the bias joins the upper half
	always_comb begin
		for (int p = 0; p < PAIR_COUNT; p++) begin
			lo_sum[p] = '0;
			hi_sum[p] = ACC_W'(bias[p]) <<< FRAC_BITS;
			for (int j = 0; j < LO_COUNT; j++) begin
				lo_sum[p] = lo_sum[p] + ACC_W'(prod[p][j]);
			end
			for (int j = LO_COUNT; j < FEATURE_COUNT; j++) begin
				hi_sum[p] = hi_sum[p] + ACC_W'(prod[p][j]);
			end
		end
	end

	always_comb begin
		for (int p = 0; p < PAIR_COUNT; p++) begin
			total[p] = lo_s2[p] + hi_s2[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en2) begin
				vld_s2 <= up_vld;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// Hold partial sums, then keep only the sign of each score
	always_ff @(posedge clk) begin
		if (en2 && up_vld) begin
			lo_s2 <= lo_sum;
			hi_s2 <= hi_sum;
		end
		if (en3 && vld_s2) begin
			for (int p = 0; p < PAIR_COUNT; p++) begin
				dec_s3[p] <= total[p] > 0;
			end
		end
	end

endmodule

// ----- rtl/ovsvm_vote.sv -----
module ovsvm_vote (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_vld,
	output logic                   up_hold,
	input  logic [2:0]             dec,
	output logic                   vld_s4,
	input  logic                   dn_stall,
	output ovsvm_pkg::class_word_t word_s4
);
	import ovsvm_pkg::*;

	logic       en;
	logic [1:0] votes0;
	logic [1:0] votes1;
	logic [1:0] votes2;
	logic [1:0] best;
	logic [1:0] best_votes;

	assign en      = !vld_s4 || !dn_stall;
	assign up_hold = !en;

	// Count votes; strict compare keeps ties on the lower class
	always_comb begin
		votes0     = 2'(dec[0]) + 2'(dec[1]);
		votes1     = 2'(!dec[0]) + 2'(dec[2]);
		votes2     = 2'(!dec[1]) + 2'(!dec[2]);
		best       = CLASS_ZERO;
		best_votes = votes0;
		if (votes1 > best_votes) begin
			best       = CLASS_ONE;
			best_votes = votes1;
		end
		if (votes2 > best_votes) begin
			best = CLASS_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_vld) begin
			word_s4.predicted_class <= best;
			word_s4.pair_decisions  <= dec;
		end
	end

endmodule

// ----- rtl/ovo_linear_svm_three_class_unit.sv -----
// One-vs-one linear SVM, three classes, four register stages:
// products, partial sums, score signs, vote and output word.
// class_valid rises once a taken feature word has passed the product, partial-sum, score-sign and vote registers.
// Throughput: one word per cycle; a stall freezes only the stages that are full.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the trained biases.
module ovo_linear_svm_three_class_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   feat_valid,
	output logic                   feat_stall,
	input  ovsvm_pkg::feat_word_t  feat,
	output logic                   class_valid,
	input  logic                   class_stall,
	output ovsvm_pkg::class_word_t class_word,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data
);
	import ovsvm_pkg::*;

	feat_vec_t feat_vec;
	bias_vec_t bias_q;
	prod_mat_t prod_s1;
	logic      vld_s1;
	logic      vld_s3;
	logic      hold_s1;
	logic      hold_s3;
	logic [2:0] dec_s3;

	assign cfg_ready = 1'b1;

	// Bias registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q[0] <= BIAS_ZERO_VS_ONE_RST;
			bias_q[1] <= BIAS_ZERO_VS_TWO_RST;
			bias_q[2] <= BIAS_ONE_VS_TWO_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BIAS_ZERO_VS_ONE: bias_q[0] <= cfg_data;
				REG_BIAS_ZERO_VS_TWO: bias_q[1] <= cfg_data;
				REG_BIAS_ONE_VS_TWO:  bias_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the feature word into an indexed vector
	always_comb begin
		feat_vec[0] = feat.feature_0;
		feat_vec[1] = feat.feature_1;
		feat_vec[2] = feat.feature_2;
		feat_vec[3] = feat.feature_3;
		feat_vec[4] = feat.feature_4;
		feat_vec[5] = feat.feature_5;
		feat_vec[6] = feat.feature_6;
	end

	ovsvm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_vld  (feat_valid),
		.up_hold (feat_stall),
		.feat    (feat_vec),
		.vld_s1  (vld_s1),
		.dn_hold (hold_s1),
		.prod_s1 (prod_s1)
	);

	ovsvm_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_vld  (vld_s1),
		.up_hold (hold_s1),
		.prod    (prod_s1),
		.bias    (bias_q),
		.vld_s3  (vld_s3),
		.dn_hold (hold_s3),
		.dec_s3  (dec_s3)
	);

	ovsvm_vote u_vote (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_vld   (vld_s3),
		.up_hold  (hold_s3),
		.dec      (dec_s3),
		.vld_s4   (class_valid),
		.dn_stall (class_stall),
		.word_s4  (class_word)
	);

endmodule

// ----- rtl/ovsvm_chk.sv -----
`include "ovo_linear_svm_three_class_unit_defines.svh"

module ovsvm_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   feat_stall,
	input logic                   class_valid,
	input logic                   class_stall,
	input ovsvm_pkg::class_word_t class_word
);
	import ovsvm_pkg::*;

	logic [2:0] dec;
	logic [1:0] cls;

	assign dec = class_word.pair_decisions;
	assign cls = class_word.predicted_class;

	// Class one wins whenever it takes both of its pairs
	`OVSVM_ASSERT_IMPL(a_class_one, class_valid && !dec[0] && dec[2], cls == CLASS_ONE)

	// Class two wins whenever it takes both of its pairs
	`OVSVM_ASSERT_IMPL(a_class_two, class_valid && !dec[1] && !dec[2], cls == CLASS_TWO)

	// An empty output stage never backs up the input
	`OVSVM_ASSERT_IMPL(a_no_stall_empty, !class_valid, !feat_stall)

	// A stalled result word stays put
	`OVSVM_ASSERT_NEXT(a_out_hold, class_valid && class_stall, class_valid && $stable(class_word))

endmodule

bind ovo_linear_svm_three_class_unit ovsvm_chk u_chk (.*);
